// ----- hdl/wl512_pkg.sv -----
// Shared types and constants for the WELL512 generator.
// No dependencies; used by every module in hdl/.
package wl512_pkg;

  localparam int unsigned POOL_WORDS = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned LOW_BITS   = 21;
  localparam int unsigned VALUE_W    = WORD_W + LOW_BITS;

  localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;

  // Pool kept rotated: entry k holds logical word (position + k) mod 16.
  typedef logic [POOL_WORDS-1:0][WORD_W-1:0] pool_t;

  typedef enum logic [1:0] {
    KIND_SEED = 2'd0,
    KIND_WORD = 2'd1,
    KIND_FRAC = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic              go;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage

// ----- hdl/wl512_advance.sv -----
// One WELL512 step on the rotated pool: fixed taps, pure XOR/shift logic.
// Depends on wl512_pkg.
module wl512_advance (
  input  wl512_pkg::pool_t               pool_in,
  output wl512_pkg::pool_t               pool_out,
  output logic [wl512_pkg::WORD_W-1:0]   word_out
);

  logic [wl512_pkg::WORD_W-1:0] a;
  logic [wl512_pkg::WORD_W-1:0] c;
  logic [wl512_pkg::WORD_W-1:0] b;
  logic [wl512_pkg::WORD_W-1:0] c2;
  logic [wl512_pkg::WORD_W-1:0] na;
  logic [wl512_pkg::WORD_W-1:0] d;
  logic [wl512_pkg::WORD_W-1:0] prev;
  logic [wl512_pkg::WORD_W-1:0] nz;

  always_comb begin
    a    = pool_in[0];
    c    = pool_in[13];
    b    = a ^ c ^ (a << 16) ^ (c << 15);
    c2   = pool_in[9] ^ (pool_in[9] >> 11);
    na   = b ^ c2;
    d    = na ^ ((na << 5) & wl512_pkg::TEMPER_MASK);
    prev = pool_in[15];
    nz   = prev ^ b ^ d ^ (prev << 2) ^ (b << 18) ^ (c2 << 28);
  end

  // Position steps back by one, so the pool rotates up one entry, with entries 0 and 1 taking the new words.
  always_comb begin
    for (int k = 2; k < wl512_pkg::POOL_WORDS; k++) begin
      pool_out[k] = pool_in[k-1];
    end
    pool_out[0] = nz;
    pool_out[1] = na;
  end

  assign word_out = nz;

endmodule

// ----- hdl/wl512_core.sv -----
// Generator state (rotated pool, position) and the per-beat update.
// Depends on wl512_pkg and wl512_advance.
module wl512_core (
  input  logic                             clk,
  input  logic                             rst,
  input  wl512_pkg::cmd_t                  cmd,
  output logic                             has_result,
  output logic [wl512_pkg::VALUE_W-1:0]    result
);

  wl512_pkg::pool_t                pool;
  wl512_pkg::pool_t                pool_next;
  logic [wl512_pkg::SLOT_W-1:0]    position;
  logic [wl512_pkg::SLOT_W-1:0]    position_next;
  logic [wl512_pkg::SLOT_W-1:0]    seed_idx;

  wl512_pkg::pool_t                pool_one;
  wl512_pkg::pool_t                pool_two;
  logic [wl512_pkg::WORD_W-1:0]    word_one;
  logic [wl512_pkg::WORD_W-1:0]    word_two;

  wl512_advance u_adv_first (
    .pool_in  (pool),
    .pool_out (pool_one),
    .word_out (word_one)
  );

  wl512_advance u_adv_second (
    .pool_in  (pool_one),
    .pool_out (pool_two),
    .word_out (word_two)
  );

  // Logical slot to rotated entry
  assign seed_idx = cmd.slot - position;

  always_comb begin
    pool_next     = pool;
    position_next = position;
    has_result    = 1'b0;
    result        = {{(wl512_pkg::VALUE_W-wl512_pkg::WORD_W){1'b0}}, word_one};
    case (cmd.kind)
      wl512_pkg::KIND_SEED: begin
        pool_next[seed_idx] = cmd.word;
      end
      wl512_pkg::KIND_WORD: begin
        pool_next     = pool_one;
        position_next = position - wl512_pkg::SLOT_W'(1);
        has_result    = 1'b1;
      end
      wl512_pkg::KIND_FRAC: begin
        pool_next     = pool_two;
        position_next = position - wl512_pkg::SLOT_W'(2);
        has_result    = 1'b1;
        result        = {word_one, word_two[wl512_pkg::LOW_BITS-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool     <= '0;
      position <= '0;
    end else if (cmd.go) begin
      pool     <= pool_next;
      position <= position_next;
    end
  end

endmodule

// ----- hdl/well512_random_generator_top.sv -----
// WELL512 generator top level: input register, core, output register.
// Depends on wl512_pkg and wl512_core.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per command: kind 0
//   writes seed_word into pool slot seed_slot, kind 1 draws a 32-bit word,
//   kind 2 draws a 53-bit fraction (first word << 21 | low 21 bits of the
//   second), kind 3 is dropped. Seed writes and kind 3 give no output beat.
//   Output channel (out_valid/out_stall) carries random_value.
//   A draw accepted into the input register moves into the output register
//   once the output is not stalled.
//   Throughput: one beat per cycle for every kind while the output is not
//   stalled; both advances of a fraction draw run in the same cycle, limited
//   by the pool register feeding back through two chained XOR update stages.
//   Reset (rst, synchronous) zeroes the pool and position and empties both
//   registers; draws before seeding return zero.
//   A stalled output holds its beat; the input register then holds one more
//   command and in_stall rises until the output beat is taken.
module well512_random_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [wl512_pkg::SLOT_W-1:0]   seed_slot,
  input  logic [wl512_pkg::WORD_W-1:0]   seed_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wl512_pkg::VALUE_W-1:0]  random_value
);

  logic                          s1_valid;
  logic [1:0]                    s1_kind;
  logic [wl512_pkg::SLOT_W-1:0]  s1_slot;
  logic [wl512_pkg::WORD_W-1:0]  s1_word;

  logic                          out_can;
  logic                          s1_go;
  wl512_pkg::cmd_t               cmd;
  logic                          has_result;
  logic [wl512_pkg::VALUE_W-1:0] result;

  assign out_can  = !out_valid || !out_stall;
  assign s1_go    = s1_valid && out_can;
  assign in_stall = s1_valid && !out_can;

  always_comb begin
    cmd.go   = s1_go;
    cmd.kind = wl512_pkg::kind_t'(s1_kind);
    cmd.slot = s1_slot;
    cmd.word = s1_word;
  end

  wl512_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_slot <= seed_slot;
      s1_word <= seed_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_can) begin
      out_valid <= s1_go && has_result;
    end
    if (s1_go && has_result) begin
      random_value <= result;
    end
  end

endmodule

// ----- hdl/wl512_checker.sv -----
// Port-level checks for the WELL512 generator, bound to the top level.
// Depends on wl512_pkg and on well512_random_generator_top port names.
module wl512_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [wl512_pkg::VALUE_W-1:0]  random_value
);

  // Held output beat must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_value))
    else $error("output beat changed while stalled");

  // Reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // Input side only backs up behind a held output beat
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // Input stall only clears once the held output beat can be taken
  a_stall_persist: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> in_stall || (out_valid && !out_stall))
    else $error("input stall dropped while output still stalled");

endmodule

bind well512_random_generator_top wl512_checker u_wl512_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .random_value (random_value)
);
